// ----- rtl/core/atan2_degrees_fixed_point_top_macros.svh -----
// Assertion macros for the atan2 degrees RTL; only atan2d_poly includes them.
`ifndef ATAN2_DEGREES_FIXED_POINT_TOP_MACROS_SVH
`define ATAN2_DEGREES_FIXED_POINT_TOP_MACROS_SVH
`ifndef SYNTH
// Checked only while out of reset.
`define AT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on every edge, reset included.
`define AT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define AT_ASSERT(lbl, prop, msg)
`define AT_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- rtl/core/atan2d_pkg.sv -----
// Shared constants and types of the atan2 degrees pipeline.
`timescale 1ns / 1ps
package atan2d_pkg;

    localparam int FRAC_BITS = 8;

    localparam int IN_W   = 15;
    localparam int SW     = IN_W + 2;
    localparam int NUM_W  = IN_W;
    localparam int DEN_W  = IN_W + 1;
    localparam int CAND_W = DEN_W + 1;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int DIV_ST = Q_W;
    localparam int R_W    = FRAC_BITS + 2;
    localparam int P_W    = 2 * R_W;
    localparam int T_W    = FRAC_BITS + 8;
    localparam int A_W    = 8;
    localparam int ANG_W  = 9;
    localparam int WK_W   = 10;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    localparam int BASE_POS  = 45;
    localparam int BASE_NEG  = 135;
    localparam int ANG_HALF  = 180;
    localparam int ANG_FULL  = 360;
    localparam int COEF_CUBE = 11;
    localparam int COEF_LIN  = -56;

    localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic y_zero;
        logic y_neg;
        logic x_neg;
        logic num_neg;
    } atan2d_tag_t;

endpackage

// ----- rtl/core/atan2d_div.sv -----
// Front stage and pipelined restoring divider producing the ratio magnitude.
`timescale 1ns / 1ps
module atan2d_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [atan2d_pkg::IN_W-1:0]   in_y,
    input  logic signed [atan2d_pkg::IN_W-1:0]   in_x,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [atan2d_pkg::Q_W-1:0]           out_q,
    output atan2d_pkg::atan2d_tag_t              out_tag
);
    import atan2d_pkg::*;

    localparam int NS = DIV_ST + 1;

    logic [NS-1:0] vld_reg, vld_next;
    logic [NS:0]   rdy;

    logic signed [SW-1:0] y_ext, x_ext, ay, num, den_s, num_abs;
    logic [NUM_W-1:0]     mag_reg, mag_next;
    logic [DEN_W-1:0]     den0_reg, den0_next;
    atan2d_tag_t          tag0_reg, tag0_next;

    logic [DEN_W-1:0]  rem_reg [DIV_ST];
    logic [DEN_W-1:0]  rem_next [DIV_ST];
    logic [DEN_W-1:0]  den_reg [DIV_ST];
    logic [Q_W-1:0]    q_reg [DIV_ST];
    logic [Q_W-1:0]    q_next [DIV_ST];
    atan2d_tag_t       tag_reg [DIV_ST];

    logic [CAND_W-1:0] cand_in [DIV_ST];
    logic [DEN_W-1:0]  den_in [DIV_ST];
    logic [Q_W-1:0]    q_in [DIV_ST];
    atan2d_tag_t       tag_in [DIV_ST];

    // A stage takes new data when it is empty or its successor moves on.
    always_comb begin
        rdy[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        for (int i = 0; i < NS; i++) begin
            if (rdy[i]) begin
                vld_next[i] = (i == 0) ? in_valid : vld_reg[(i == 0) ? 0 : i - 1];
            end else begin
                vld_next[i] = vld_reg[i];
            end
        end
    end

    assign in_ready = rdy[0];

    // Fold the vector into a numerator and a non-negative denominator.
    always_comb begin
        y_ext = SW'(in_y);
        x_ext = SW'(in_x);
        ay    = in_y[IN_W-1] ? -y_ext : y_ext;
        if (in_x[IN_W-1]) begin
            num   = x_ext + ay;
            den_s = ay - x_ext;
        end else begin
            num   = x_ext - ay;
            den_s = x_ext + ay;
        end
        num_abs           = num[SW-1] ? -num : num;
        mag_next          = num_abs[NUM_W-1:0];
        den0_next         = den_s[DEN_W-1:0];
        tag0_next.y_zero  = (in_y == '0);
        tag0_next.y_neg   = in_y[IN_W-1];
        tag0_next.x_neg   = in_x[IN_W-1];
        tag0_next.num_neg = num[SW-1];
    end

    // Each divider stage settles one quotient bit, the weight of 1.0 first.
    always_comb begin
        cand_in[0] = CAND_W'(mag_reg);
        den_in[0]  = den0_reg;
        q_in[0]    = '0;
        tag_in[0]  = tag0_reg;
        for (int k = 1; k < DIV_ST; k++) begin
            cand_in[k] = {rem_reg[k-1], 1'b0};
            den_in[k]  = den_reg[k-1];
            q_in[k]    = q_reg[k-1];
            tag_in[k]  = tag_reg[k-1];
        end
        for (int k = 0; k < DIV_ST; k++) begin
            if (cand_in[k] >= CAND_W'(den_in[k])) begin
                rem_next[k] = DEN_W'(cand_in[k] - CAND_W'(den_in[k]));
                q_next[k]   = {q_in[k][Q_W-2:0], 1'b1};
            end else begin
                rem_next[k] = DEN_W'(cand_in[k]);
                q_next[k]   = {q_in[k][Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            mag_reg  <= mag_next;
            den0_reg <= den0_next;
            tag0_reg <= tag0_next;
        end
        for (int k = 0; k < DIV_ST; k++) begin
            if (rdy[k+1]) begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_in[k];
                q_reg[k]   <= q_next[k];
                tag_reg[k] <= tag_in[k];
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_q     = q_reg[DIV_ST-1];
    assign out_tag   = tag_reg[DIV_ST-1];

endmodule

// ----- rtl/core/atan2d_poly.sv -----
// Signed ratio, cubic polynomial and quadrant folding into whole degrees.
`timescale 1ns / 1ps
`include "atan2_degrees_fixed_point_top_macros.svh"
module atan2d_poly (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [atan2d_pkg::Q_W-1:0]    in_q,
    input  atan2d_pkg::atan2d_tag_t       in_tag,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [atan2d_pkg::ANG_W-1:0]  out_angle
);
    import atan2d_pkg::*;

    localparam int NS = 4;

    logic [NS-1:0] vld_reg, vld_next;
    logic [NS:0]   rdy;

    logic signed [R_W-1:0]  r0_reg, r_next, r1_reg, r2s;
    logic signed [P_W-1:0]  rr_reg, rr_next;
    logic signed [P_W-1:0]  cr_reg, cr_next;
    logic signed [R_W-1:0]  c1;
    logic signed [T_W-1:0]  t_reg, t_next;
    logic signed [A_W-1:0]  a_s;
    logic signed [WK_W-1:0] base, raw;
    logic [ANG_W-1:0]       angle_reg, angle_next;
    atan2d_tag_t            tag0_reg, tag1_reg, tag2_reg;

    always_comb begin
        rdy[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        for (int i = 0; i < NS; i++) begin
            if (rdy[i]) begin
                vld_next[i] = (i == 0) ? in_valid : vld_reg[(i == 0) ? 0 : i - 1];
            end else begin
                vld_next[i] = vld_reg[i];
            end
        end
    end

    assign in_ready = rdy[0];

    // Truncation toward zero: the magnitude quotient takes the numerator's sign.
    always_comb begin
        r_next  = in_tag.num_neg ? -R_W'(in_q) : R_W'(in_q);
        rr_next = P_W'(r_next) * P_W'(r_next);
    end

    always_comb begin
        r2s     = rr_reg[FRAC_BITS +: R_W];
        cr_next = P_W'(r2s) * P_W'(r0_reg);
    end

    // Bit-selects of the two's complement products give the floor shift.
    always_comb begin
        c1     = cr_reg[FRAC_BITS +: R_W];
        t_next = T_W'(c1) * T_W'(COEF_CUBE) + T_W'(r1_reg) * T_W'(COEF_LIN);
    end

    always_comb begin
        a_s  = t_reg[FRAC_BITS +: A_W];
        base = tag2_reg.x_neg ? WK_W'(BASE_NEG) : WK_W'(BASE_POS);
        raw  = base + WK_W'(a_s);
        if (tag2_reg.y_zero) begin
            raw = tag2_reg.x_neg ? WK_W'(ANG_HALF) : '0;
        end
        if (tag2_reg.y_neg) begin
            raw = WK_W'(ANG_FULL) - raw;
        end
        angle_next = raw[ANG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            r0_reg   <= r_next;
            rr_reg   <= rr_next;
            tag0_reg <= in_tag;
        end
        if (rdy[1]) begin
            r1_reg   <= r0_reg;
            cr_reg   <= cr_next;
            tag1_reg <= tag0_reg;
        end
        if (rdy[2]) begin
            t_reg    <= t_next;
            tag2_reg <= tag1_reg;
        end
        if (rdy[3]) begin
            angle_reg <= angle_next;
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_angle = angle_reg;

    `AT_ASSERT_RST(a_rst_empty, !aresetn |=> !out_valid, "pipeline not empty after reset")
    `AT_ASSERT(a_ratio_bound, in_valid && !in_tag.y_zero |-> in_q <= Q_ONE, "ratio above one")
    `AT_ASSERT(a_angle_range, out_valid |-> angle_reg <= ANG_W'(ANG_FULL), "angle above 360")
    `AT_ASSERT(a_axis_angle, vld_reg[2] && tag2_reg.y_zero && rdy[3] |=> angle_reg == '0 || angle_reg == ANG_W'(ANG_HALF), "axis angle wrong")

endmodule

// ----- rtl/core/atan2_degrees_fixed_point_top.sv -----
// Top level of the approximate atan2 in whole degrees.
`timescale 1ns / 1ps
// Usage:
// The slave channel takes one (y, x) request per cycle while s_tready is high:
// y in s_tdata[14:0], x in s_tdata[29:15], both signed, nominally within +-16383.
// The master channel returns one angle per request, 0 to 360 degrees, in
// m_tdata[8:0], in request order.
// A request passes fourteen register stages and the first one loads on the
// accepting edge: one folding stage, nine restoring divider stages (one
// quotient bit each) and four stages for the signed ratio, two multiplies
// and the final sum and fold.
// Throughput is one request per cycle while m_tready is high; the divider
// pipeline sets it.
// Every stage carries its own valid bit. When the receiver holds m_tready
// low, the full stages hold their data and empty stages still fill, so
// s_tready drops only once the whole pipeline is full.
// A synchronous active-low reset empties the pipeline; no request is
// pending afterwards.
module atan2_degrees_fixed_point_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [atan2d_pkg::S_TDATA_W-1:0]   s_tdata,  // y_value[14:0], x_value[29:15]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [atan2d_pkg::M_TDATA_W-1:0]   m_tdata   // angle_deg[8:0]
);
    import atan2d_pkg::*;

    logic              div_valid, div_ready;
    logic [Q_W-1:0]    div_q;
    atan2d_tag_t       div_tag;
    logic [ANG_W-1:0]  angle;

    atan2d_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_y      (s_tdata[IN_W-1:0]),
        .in_x      (s_tdata[2*IN_W-1:IN_W]),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_q     (div_q),
        .out_tag   (div_tag)
    );

    atan2d_poly u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_q      (div_q),
        .in_tag    (div_tag),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_angle (angle)
    );

    assign m_tdata = M_TDATA_W'(angle);

endmodule

// ----- verif/atan2_degrees_fixed_point_checker.sv -----
// Checker that predicts the angle of every accepted request and compares it with the result stream.
`timescale 1ns / 1ps
module atan2_degrees_fixed_point_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [atan2d_pkg::S_TDATA_W-1:0]   s_tdata,  // y_value[14:0], x_value[29:15]
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [atan2d_pkg::M_TDATA_W-1:0]   m_tdata,  // angle_deg[8:0]
    output int                                 mismatches,
    output int                                 pending
);
    import atan2d_pkg::*;

    localparam int PRINT_CAP = 100;

    typedef struct {
        logic signed [IN_W-1:0] y_value;
        logic signed [IN_W-1:0] x_value;
        logic [ANG_W-1:0]       angle_deg;
    } angle_entry_t;

    angle_entry_t angles_due[$];
    int           fail_total = 0;

    assign mismatches = fail_total;

    function automatic logic [ANG_W-1:0] expected_angle(
        logic signed [IN_W-1:0] y_value, logic signed [IN_W-1:0] x_value);
        longint y;
        longint x;
        longint ay;
        longint num;
        longint den;
        longint base;
        longint ratio;
        longint cube;
        longint angle;
        y  = y_value;
        x  = x_value;
        ay = (y < 0) ? -y : y;
        if (y == 0) begin
            angle = (x >= 0) ? 0 : ANG_HALF;
        end else begin
            if (x >= 0) begin
                num  = x - ay;
                den  = x + ay;
                base = BASE_POS;
            end else begin
                num  = x + ay;
                den  = ay - x;
                base = BASE_NEG;
            end
            // Division truncates toward zero; the shifts floor toward minus infinity.
            ratio = (num * (longint'(1) << FRAC_BITS)) / den;
            cube  = (ratio * ratio) >>> FRAC_BITS;
            cube  = ((cube * ratio) >>> FRAC_BITS) * COEF_CUBE;
            angle = base + ((COEF_LIN * ratio + cube) >>> FRAC_BITS);
        end
        if (y < 0) begin
            angle = ANG_FULL - angle;
        end
        return ANG_W'(angle);
    endfunction

    task automatic report_mismatch(string what);
        if (fail_total < PRINT_CAP) begin
            $display("%0t ns: angle mismatch: %s", $time, what);
        end
        fail_total++;
    endtask

    always @(posedge aclk) begin
        angle_entry_t due;
        if (aresetn) begin
            // Results are matched before new requests are queued, so a result can
            // never pair with a request accepted on the same edge.
            if (m_tvalid && m_tready) begin
                if (angles_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no request outstanding",
                                              m_tdata[ANG_W-1:0]));
                end else begin
                    due = angles_due.pop_front();
                    if (m_tdata[ANG_W-1:0] != due.angle_deg) begin
                        report_mismatch($sformatf("y=%0d x=%0d gave %0d, expected %0d",
                                                  due.y_value, due.x_value,
                                                  m_tdata[ANG_W-1:0], due.angle_deg));
                    end
                    if (m_tdata[M_TDATA_W-1:ANG_W] != '0) begin
                        report_mismatch($sformatf("y=%0d x=%0d left padding bits at %h",
                                                  due.y_value, due.x_value,
                                                  m_tdata[M_TDATA_W-1:ANG_W]));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                due.y_value   = s_tdata[IN_W-1:0];
                due.x_value   = s_tdata[2*IN_W-1:IN_W];
                due.angle_deg = expected_angle(due.y_value, due.x_value);
                angles_due.push_back(due);
            end
        end
        pending <= angles_due.size();
    end

endmodule

// ----- verif/atan2_degrees_fixed_point_top_tb.sv -----
// Testbench top: drives angle requests and result backpressure and prints the verdict.
`timescale 1ns / 1ps
module atan2_degrees_fixed_point_top_tb;
    import atan2d_pkg::*;

    localparam int LATENCY   = 14;
    localparam int LONG_HOLD = 80;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;   // y_value[14:0], x_value[29:15]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;   // angle_deg[8:0]

    int mismatches;
    int pending;
    bit calm         = 1'b0;
    bit hold_request = 1'b0;

    atan2_degrees_fixed_point_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    atan2_degrees_fixed_point_checker i_angle_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic signed [IN_W-1:0] value_between(int lo, int hi);
        return IN_W'(int'($urandom_range(0, hi - lo)) + lo);
    endfunction

    function automatic logic signed [IN_W-1:0] edge_value();
        int picks[6] = '{-16384, -16383, -1, 0, 1, 16383};
        return IN_W'(picks[$urandom_range(0, 5)]);
    endfunction

    task automatic pick_pair(output logic signed [IN_W-1:0] y, output logic signed [IN_W-1:0] x);
        int mag;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                y = IN_W'($urandom);
                x = IN_W'($urandom);
            end
            4: begin
                y = value_between(-20, 20);
                x = value_between(-20, 20);
            end
            5: begin
                y = '0;
                x = IN_W'($urandom);
            end
            6: begin
                // Close to an axis, where the ratio sits near plus or minus one.
                y = ($urandom_range(0, 1) != 0) ? value_between(-3, 3) : IN_W'($urandom);
                x = ($urandom_range(0, 1) != 0) ? value_between(-3, 3) : IN_W'($urandom);
            end
            7, 8: begin
                // Near the diagonals, where the ratio is close to zero.
                mag = $urandom_range(1, 16383);
                y = IN_W'(($urandom_range(0, 1) != 0) ? mag : -mag);
                mag = mag + int'($urandom_range(0, 6)) - 3;
                x = IN_W'(($urandom_range(0, 1) != 0) ? mag : -mag);
            end
            default: begin
                y = edge_value();
                x = edge_value();
            end
        endcase
    endtask

    task automatic send_request(logic signed [IN_W-1:0] y, logic signed [IN_W-1:0] x,
                                bit allow_gap);
        s_tdata  <= {{(S_TDATA_W - 2 * IN_W){1'b0}}, x, y};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (allow_gap && !calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic send_random(int count, bit allow_gap);
        logic signed [IN_W-1:0] y;
        logic signed [IN_W-1:0] x;
        repeat (count) begin
            pick_pair(y, x);
            send_request(y, x, allow_gap);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Result side backpressure, including one long hold-off on request.
    initial begin : result_flow
        bit served;
        served   = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (calm) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else if (hold_request && !served) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                served = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            if (!hold_request) begin
                served = 1'b0;
            end
        end
    end

    initial begin : request_flow
        int fixed_y[] = '{0, 0, 0, 0, 16383, -16383, 1, -1, 16383, -16383, 16383, -16383,
                          1, -1, 1, -1, -16384, -16384, 16383, -16384, 1, -1, 5, -7};
        int fixed_x[] = '{0, 16383, -1, -16384, 0, 0, 0, 0, 16383, 16383, -16383, -16383,
                          16383, 16383, -16383, -16383, -16384, 16383, -16384, 0, 1, -1, -3, 2};
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Axes, corners, the out-of-range minimum and the fold that yields 360.
        foreach (fixed_y[i]) begin
            send_request(IN_W'(fixed_y[i]), IN_W'(fixed_x[i]), 1'b1);
        end

        send_random(400, 1'b1);

        // The sender pauses until every result is back.
        wait_drained();

        // The receiver holds off while requests keep coming, so the pipeline fills.
        hold_request <= 1'b1;
        send_random(60, 1'b0);
        hold_request <= 1'b0;

        send_random(350, 1'b1);

        calm <= 1'b1;
        send_random(120, 1'b0);

        wait_drained();
        repeat (LATENCY + 6) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
